// File: sv/packet_action_header_rewriter_core_assert.svh
// Assertion macros shared by the header rewriter RTL
`ifndef PACKET_ACTION_HEADER_REWRITER_CORE_ASSERT_SVH
`define PACKET_ACTION_HEADER_REWRITER_CORE_ASSERT_SVH

// same-cycle implication
`define PAHR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pahr assertion failed");

// next-cycle implication
`define PAHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pahr assertion failed");

`endif

// File: sv/pahr_pkg.sv
// Types, constants and checksum helper for the header rewriter
package pahr_pkg;

  localparam int unsigned DEFAULT_PORT_COUNT = 256;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
  localparam logic [15:0] ECHO_SUM_ADJ   = 16'h0800;
  localparam logic [13:0] LEN_ETH        = 14'd14;
  localparam logic [13:0] LEN_IP         = 14'd34;
  localparam logic [13:0] LEN_ICMP       = 14'd42;

  typedef enum logic [2:0] {
    ACT_PASS     = 3'd0,
    ACT_DROP     = 3'd1,
    ACT_ECHO     = 3'd2,
    ACT_REDIRECT = 3'd3,
    ACT_NAT      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_TX       = 2'd2,
    VERDICT_REDIRECT = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [13:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [7:0]  icmp_kind;
    logic [15:0] icmp_sum_in;
    logic [15:0] ip_sum_in;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic        entry_hit;
    logic [2:0]  entry_action;
    logic [31:0] entry_new_addr;
    logic [7:0]  entry_port;
  } in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  out_port;
    logic        swap_macs;
    logic [7:0]  icmp_kind_out;
    logic [15:0] icmp_sum_out;
    logic [15:0] ip_sum_out;
    logic [31:0] source_addr_out;
    logic [31:0] dest_addr_out;
    logic        entry_drop_bump;
    logic [63:0] total_drops;
  } res_t;

  // incremental IPv4 header checksum update for a new destination address
  function automatic logic [15:0] dnat_sum(logic [15:0] sum, logic [31:0] old_a,
                                           logic [31:0] new_a);
    logic [18:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = {3'b0, ~sum} + {3'b0, ~old_a[31:16]} + {3'b0, ~old_a[15:0]}
       + {3'b0, new_a[31:16]} + {3'b0, new_a[15:0]};
    f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    return ~f2;
  endfunction

endpackage

// File: sv/pahr_rewrite.sv
// Verdict decision and header field rewrite for one item
module pahr_rewrite #(
  parameter int unsigned PORT_COUNT = pahr_pkg::DEFAULT_PORT_COUNT
) (
  input  pahr_pkg::in_t  item_i,
  input  logic [63:0]    drop_total_i,
  output pahr_pkg::res_t res_o
);
  import pahr_pkg::*;

  logic        active;
  logic        echo_ok;
  logic        port_ok;
  logic [16:0] echo_t;
  logic [15:0] echo_sum;
  logic [15:0] nat_sum;
  action_e     act;

  assign active  = (item_i.frame_len >= LEN_ETH) && (item_i.ether_type == ETHERTYPE_IPV4)
                && (item_i.frame_len >= LEN_IP) && item_i.entry_hit;
  assign echo_ok = (item_i.ip_protocol == PROTO_ICMP) && (item_i.frame_len >= LEN_ICMP)
                && (item_i.icmp_kind == ICMP_ECHO_REQ);
  assign port_ok = {24'b0, item_i.entry_port} < PORT_COUNT;
  assign echo_t  = {1'b0, item_i.icmp_sum_in} + {1'b0, ECHO_SUM_ADJ};
  assign echo_sum = echo_t[16] ? (echo_t[15:0] + 16'd1) : echo_t[15:0];
  assign nat_sum = dnat_sum(item_i.ip_sum_in, item_i.dest_addr, item_i.entry_new_addr);
  assign act     = action_e'(item_i.entry_action);

  always_comb begin
    res_o.verdict         = VERDICT_PASS;
    res_o.out_port        = 8'd0;
    res_o.swap_macs       = 1'b0;
    res_o.icmp_kind_out   = item_i.icmp_kind;
    res_o.icmp_sum_out    = item_i.icmp_sum_in;
    res_o.ip_sum_out      = item_i.ip_sum_in;
    res_o.source_addr_out = item_i.source_addr;
    res_o.dest_addr_out   = item_i.dest_addr;
    res_o.entry_drop_bump = 1'b0;
    if (active) begin
      case (act)
        ACT_DROP: begin
          res_o.verdict         = VERDICT_DROP;
          res_o.entry_drop_bump = 1'b1;
        end
        ACT_ECHO: begin
          if (echo_ok) begin
            res_o.verdict         = VERDICT_TX;
            res_o.swap_macs       = 1'b1;
            res_o.icmp_kind_out   = ICMP_ECHO_REP;
            res_o.icmp_sum_out    = echo_sum;
            res_o.source_addr_out = item_i.dest_addr;
            res_o.dest_addr_out   = item_i.source_addr;
          end
        end
        ACT_REDIRECT: begin
          if (item_i.entry_new_addr != 32'd0) begin
            res_o.ip_sum_out    = nat_sum;
            res_o.dest_addr_out = item_i.entry_new_addr;
          end
          if (port_ok) begin
            res_o.verdict  = VERDICT_REDIRECT;
            res_o.out_port = item_i.entry_port;
          end else begin
            res_o.verdict = VERDICT_DROP;
          end
        end
        ACT_NAT: begin
          res_o.ip_sum_out    = nat_sum;
          res_o.dest_addr_out = item_i.entry_new_addr;
        end
        default: begin
        end
      endcase
    end
    res_o.total_drops = drop_total_i + {63'b0, res_o.entry_drop_bump};
  end

endmodule

// File: sv/pahr_out_stage.sv
// Result register with valid/ready handshake
module pahr_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  pahr_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pahr_pkg::res_t res_o
);
  import pahr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/packet_action_header_rewriter_core.sv
// Top level of the packet action header rewriter
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_ready_o   | frame header fields + lookup entry
//   result  | out       | out_valid_o / out_ready_i | verdict, rewritten fields, drop total
//
// One item per cycle while out_ready_i is high; stages: input register, result register.
// The path between the two registers is the checksum adder tree and the 64-bit increment.
// Reset clears both valid flags and the drop total; payload registers are not reset.
// A stalled result holds the result register; the input register drains into it once free.
`include "packet_action_header_rewriter_core_assert.svh"

module packet_action_header_rewriter_core #(
  parameter int unsigned PORT_COUNT = pahr_pkg::DEFAULT_PORT_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] frame_len_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [7:0]  icmp_kind_i,
  input  logic [15:0] icmp_sum_in_i,
  input  logic [15:0] ip_sum_in_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic        entry_hit_i,
  input  logic [2:0]  entry_action_i,
  input  logic [31:0] entry_new_addr_i,
  input  logic [7:0]  entry_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  out_port_o,
  output logic        swap_macs_o,
  output logic [7:0]  icmp_kind_out_o,
  output logic [15:0] icmp_sum_out_o,
  output logic [15:0] ip_sum_out_o,
  output logic [31:0] source_addr_out_o,
  output logic [31:0] dest_addr_out_o,
  output logic        entry_drop_bump_o,
  output logic [63:0] total_drops_o
);
  import pahr_pkg::*;

  logic        in_valid_q, in_valid_d;
  in_t         item_q;
  logic [63:0] drop_total_q, drop_total_d;
  logic        out_free;
  logic        advance;
  res_t        res_comb;
  res_t        res_out;

  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !out_free);
  assign drop_total_d = advance ? res_comb.total_drops : drop_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      drop_total_q <= 64'd0;
    end else begin
      in_valid_q   <= in_valid_d;
      drop_total_q <= drop_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.frame_len      <= frame_len_i;
      item_q.ether_type     <= ether_type_i;
      item_q.ip_protocol    <= ip_protocol_i;
      item_q.icmp_kind      <= icmp_kind_i;
      item_q.icmp_sum_in    <= icmp_sum_in_i;
      item_q.ip_sum_in      <= ip_sum_in_i;
      item_q.source_addr    <= source_addr_i;
      item_q.dest_addr      <= dest_addr_i;
      item_q.entry_hit      <= entry_hit_i;
      item_q.entry_action   <= entry_action_i;
      item_q.entry_new_addr <= entry_new_addr_i;
      item_q.entry_port     <= entry_port_i;
    end
  end

  pahr_rewrite #(
    .PORT_COUNT(PORT_COUNT)
  ) u_rewrite (
    .item_i      (item_q),
    .drop_total_i(drop_total_q),
    .res_o       (res_comb)
  );

  pahr_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_q),
    .ready_o(out_free),
    .res_i  (res_comb),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (res_out)
  );

  assign verdict_o         = res_out.verdict;
  assign out_port_o        = res_out.out_port;
  assign swap_macs_o       = res_out.swap_macs;
  assign icmp_kind_out_o   = res_out.icmp_kind_out;
  assign icmp_sum_out_o    = res_out.icmp_sum_out;
  assign ip_sum_out_o      = res_out.ip_sum_out;
  assign source_addr_out_o = res_out.source_addr_out;
  assign dest_addr_out_o   = res_out.dest_addr_out;
  assign entry_drop_bump_o = res_out.entry_drop_bump;
  assign total_drops_o     = res_out.total_drops;

  `PAHR_ASSERT_NEXT(a_total_holds, clk_i, rst_ni, !(advance && res_comb.entry_drop_bump), drop_total_q == $past(drop_total_q))
  `PAHR_ASSERT_NEXT(a_total_bumps, clk_i, rst_ni, advance && res_comb.entry_drop_bump, drop_total_q == $past(drop_total_q) + 64'd1)
  `PAHR_ASSERT_NOW(a_swap_tx, clk_i, rst_ni, out_valid_o && swap_macs_o, verdict_o == VERDICT_TX)
  `PAHR_ASSERT_NOW(a_bump_drop, clk_i, rst_ni, out_valid_o && entry_drop_bump_o, verdict_o == VERDICT_DROP)
  `PAHR_ASSERT_NOW(a_port_zero, clk_i, rst_ni, out_valid_o && (verdict_o != VERDICT_REDIRECT), out_port_o == 8'd0)

endmodule
